// ----- sv/cdudc_pkg.sv -----
// Shared types, codes and calendar helper functions for the date counter.
`default_nettype none
package cdudc_pkg;

  localparam logic [1:0] FUNC_FWD  = 2'd0;
  localparam logic [1:0] FUNC_BACK = 2'd1;
  localparam logic [1:0] FUNC_LOAD = 2'd2;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_BAD_MONTH = 2'd1;
  localparam logic [1:0] ERR_BAD_DAY   = 2'd2;
  localparam logic [1:0] ERR_RANGE     = 2'd3;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [3:0]  MONTH_RESET = 4'd1;
  localparam logic [4:0]  DAY_RESET   = 5'd1;
  localparam logic [13:0] YEAR_RESET  = 14'd1900;
  localparam logic [7:0]  CENT_RESET  = 8'd19;
  localparam logic [6:0]  YY_RESET    = 7'd0;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAYS_31   = 5'd31;
  localparam logic [4:0] DAYS_30   = 5'd30;
  localparam logic [4:0] DAYS_29   = 5'd29;
  localparam logic [4:0] DAYS_28   = 5'd28;
  localparam logic [6:0] YY_LAST   = 7'd99;

  // Reciprocal of 100 scaled by 2^19; exact for every 14-bit year.
  localparam logic [26:0] RECIP_100 = 27'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [13:0] load_year;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [13:0] cur_year;
    logic        is_leap;
    logic [1:0]  error_code;
  } res_item_t;

  // Registered command plus the loaded year split into century and year of century.
  typedef struct packed {
    cmd_item_t  cmd;
    logic [7:0] load_cent;
    logic [6:0] load_yy;
  } stage_t;

  // The year is kept both whole and split so the leap rule needs no division.
  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
    logic [7:0]  cent;
    logic [6:0]  yy;
  } date_t;

  function automatic logic leap_of(input logic [7:0] cent, input logic [6:0] yy);
    logic leap;
    if (yy == 7'd0) begin
      leap = (cent[1:0] == 2'd0);
    end else begin
      leap = (yy[1:0] == 2'd0);
    end
    return leap;
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      MONTH_FEB:                 len = leap ? DAYS_29 : DAYS_28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = DAYS_30;
      default:                   len = DAYS_31;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] cent_of(input logic [13:0] year);
    logic [26:0] prod;
    prod = {13'd0, year} * RECIP_100;
    return prod[26:RECIP_SHIFT];
  endfunction

endpackage
`default_nettype wire

// ----- sv/calendar_date_up_down_counter_core.sv -----
// Gregorian date counter: input register, next-date logic, date and result registers.
// An accepted command item is held in the input register; its result is then registered in the result register.
// Throughput: one item per cycle while results are taken; the input register refills as the result register drains.
// Reset (synchronous): date returns to January 1, 1900 and both registers go empty.
// A stalled result holds the input register, which then holds off new items.
`default_nettype none
module calendar_date_up_down_counter_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cdudc_pkg::cmd_item_t cmd,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output cdudc_pkg::res_item_t      res
);

  logic              stg_valid;
  cdudc_pkg::stage_t stg;
  cdudc_pkg::date_t  date;
  cdudc_pkg::date_t  date_next;
  logic              leap_next;
  logic [1:0]        err_next;
  logic              adv;

  assign adv = stg_valid && (!res_valid || res_ready);

  cdudc_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .adv       (adv),
    .stg_valid (stg_valid),
    .stg       (stg)
  );

  cdudc_next u_next (
    .stg      (stg),
    .cur      (date),
    .nxt      (date_next),
    .nxt_leap (leap_next),
    .err      (err_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      date.month <= cdudc_pkg::MONTH_RESET;
      date.day   <= cdudc_pkg::DAY_RESET;
      date.year  <= cdudc_pkg::YEAR_RESET;
      date.cent  <= cdudc_pkg::CENT_RESET;
      date.yy    <= cdudc_pkg::YY_RESET;
      res_valid  <= 1'b0;
    end else if (adv) begin
      date      <= date_next;
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.cur_month  <= date_next.month;
      res.cur_day    <= date_next.day;
      res.cur_year   <= date_next.year;
      res.is_leap    <= leap_next;
      res.error_code <= err_next;
    end
  end

  a_date_in_range: assert property (@(posedge clk) disable iff (rst)
    (date.month >= 4'd1) && (date.month <= cdudc_pkg::MONTH_DEC) &&
    (date.day >= 5'd1) && (date.year <= cdudc_pkg::YEAR_MAX))
    else $error("date register out of range");

  a_year_split: assert property (@(posedge clk) disable iff (rst)
    date.year == ({6'd0, date.cent} * 14'd100) + {7'd0, date.yy})
    else $error("split year disagrees with whole year");

  a_err_keeps_date: assert property (@(posedge clk) disable iff (rst)
    (adv && (err_next != cdudc_pkg::ERR_OK)) |=> (date == $past(date)))
    else $error("rejected item changed the date");

  a_leap_mult4: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.is_leap) |-> (res.cur_year[1:0] == 2'd0))
    else $error("leap flag on a year not divisible by four");

  a_result_matches_date: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.cur_year == date.year && res.cur_day == date.day))
    else $error("result does not show the held date");

endmodule
`default_nettype wire

// ----- sv/cdudc_in_stage.sv -----
// Input register: holds one command item and splits its load year by 100.
`default_nettype none
module cdudc_in_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cdudc_pkg::cmd_item_t cmd,
  input  wire logic                 adv,
  output logic                      stg_valid,
  output cdudc_pkg::stage_t         stg
);

  logic [7:0]  cent_w;
  logic [13:0] rem_w;

  assign cmd_ready = !stg_valid || adv;

  always_comb begin
    cent_w = cdudc_pkg::cent_of(cmd.load_year);
    rem_w  = cmd.load_year - ({6'd0, cent_w} * 14'd100);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (cmd_ready) begin
      stg_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      stg.cmd       <= cmd;
      stg.load_cent <= cent_w;
      stg.load_yy   <= rem_w[6:0];
    end
  end

endmodule
`default_nettype wire

// ----- sv/cdudc_next.sv -----
// Next-date logic: day steps with month and year rollover, and checked loads.
`default_nettype none
module cdudc_next (
  input  wire cdudc_pkg::stage_t stg,
  input  wire cdudc_pkg::date_t  cur,
  output cdudc_pkg::date_t       nxt,
  output logic                   nxt_leap,
  output logic [1:0]             err
);

  logic       cur_leap;
  logic       load_leap;
  logic [4:0] cur_len;
  logic [4:0] prev_len;
  logic [4:0] load_len;

  always_comb begin
    nxt       = cur;
    err       = cdudc_pkg::ERR_OK;
    cur_leap  = cdudc_pkg::leap_of(cur.cent, cur.yy);
    cur_len   = cdudc_pkg::days_in(cur.month, cur_leap);
    prev_len  = cdudc_pkg::days_in(cur.month - 4'd1, cur_leap);
    load_leap = cdudc_pkg::leap_of(stg.load_cent, stg.load_yy);
    load_len  = cdudc_pkg::days_in(stg.cmd.load_month, load_leap);

    case (stg.cmd.func)
      cdudc_pkg::FUNC_FWD: begin
        if (cur.day < cur_len) begin
          nxt.day = cur.day + 5'd1;
        end else if (cur.month < cdudc_pkg::MONTH_DEC) begin
          nxt.day   = 5'd1;
          nxt.month = cur.month + 4'd1;
        end else if (cur.year >= cdudc_pkg::YEAR_MAX) begin
          err = cdudc_pkg::ERR_RANGE;
        end else begin
          nxt.day   = 5'd1;
          nxt.month = 4'd1;
          nxt.year  = cur.year + 14'd1;
          if (cur.yy == cdudc_pkg::YY_LAST) begin
            nxt.yy   = 7'd0;
            nxt.cent = cur.cent + 8'd1;
          end else begin
            nxt.yy = cur.yy + 7'd1;
          end
        end
      end
      cdudc_pkg::FUNC_BACK: begin
        if (cur.day > 5'd1) begin
          nxt.day = cur.day - 5'd1;
        end else if (cur.month > 4'd1) begin
          nxt.month = cur.month - 4'd1;
          nxt.day   = prev_len;
        end else if (cur.year == 14'd0) begin
          err = cdudc_pkg::ERR_RANGE;
        end else begin
          nxt.month = cdudc_pkg::MONTH_DEC;
          nxt.day   = cdudc_pkg::DAYS_31;
          nxt.year  = cur.year - 14'd1;
          if (cur.yy == 7'd0) begin
            nxt.yy   = cdudc_pkg::YY_LAST;
            nxt.cent = cur.cent - 8'd1;
          end else begin
            nxt.yy = cur.yy - 7'd1;
          end
        end
      end
      cdudc_pkg::FUNC_LOAD: begin
        // Checks run month, then day, then year; any failure keeps the date.
        if (stg.cmd.load_month < 4'd1 || stg.cmd.load_month > cdudc_pkg::MONTH_DEC) begin
          err = cdudc_pkg::ERR_BAD_MONTH;
        end else if (stg.cmd.load_day == 5'd0 || stg.cmd.load_day > load_len) begin
          err = cdudc_pkg::ERR_BAD_DAY;
        end else if (stg.cmd.load_year > cdudc_pkg::YEAR_MAX) begin
          err = cdudc_pkg::ERR_RANGE;
        end else begin
          nxt.month = stg.cmd.load_month;
          nxt.day   = stg.cmd.load_day;
          nxt.year  = stg.cmd.load_year;
          nxt.cent  = stg.load_cent;
          nxt.yy    = stg.load_yy;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase

    nxt_leap = cdudc_pkg::leap_of(nxt.cent, nxt.yy);
  end

endmodule
`default_nettype wire

// ----- bench/calendar_date_up_down_counter_core_tb.sv -----
// Self-checking testbench for the Gregorian date counter core.
module calendar_date_up_down_counter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdudc_pkg::*;

  // The package leaves the fourth command code unnamed; the block ignores it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1630;
  localparam int CALM_TAIL = 300;

  // Tracks the date the block should hold and the results still owed by it.
  class date_tracker;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
    res_item_t   expected_dates[$];
    int          errors;
    int          checked;
    int          code_seen[4];
    int          year_rollovers;
    int          lowest_year;
    int          highest_year;

    function new();
      month = MONTH_RESET;
      day = DAY_RESET;
      year = YEAR_RESET;
      lowest_year = YEAR_RESET;
      highest_year = YEAR_RESET;
    endfunction

    static function bit leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int days_of(int m, int y);
      case (m)
        2: return leap(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default: return 31;
      endcase
    endfunction

    // Applies one accepted command to the tracked date and queues the result it owes.
    function void note_command(cmd_item_t c);
      res_item_t want;
      logic [1:0] code;
      logic [13:0] old_year;
      code = ERR_OK;
      old_year = year;
      case (c.func)
        FUNC_FWD: begin
          if (day < days_of(month, year)) begin
            day++;
          end else if (month < MONTH_DEC) begin
            day = DAY_RESET;
            month++;
          end else if (year >= YEAR_MAX) begin
            code = ERR_RANGE;
          end else begin
            day = DAY_RESET;
            month = MONTH_RESET;
            year++;
          end
        end
        FUNC_BACK: begin
          if (day > 1) begin
            day--;
          end else if (month > 1) begin
            month--;
            day = 5'(days_of(month, year));
          end else if (year == 0) begin
            code = ERR_RANGE;
          end else begin
            year--;
            month = MONTH_DEC;
            day = DAYS_31;
          end
        end
        FUNC_LOAD: begin
          if (c.load_month < 1 || c.load_month > MONTH_DEC) begin
            code = ERR_BAD_MONTH;
          end else if (c.load_day < 1 || c.load_day > days_of(c.load_month, c.load_year)) begin
            code = ERR_BAD_DAY;
          end else if (c.load_year > YEAR_MAX) begin
            code = ERR_RANGE;
          end else begin
            month = c.load_month;
            day = c.load_day;
            year = c.load_year;
          end
        end
        default: begin
        end
      endcase
      if (c.func != FUNC_LOAD && year != old_year) year_rollovers++;
      if (year < lowest_year) lowest_year = year;
      if (year > highest_year) highest_year = year;
      want.cur_month = month;
      want.cur_day = day;
      want.cur_year = year;
      want.is_leap = leap(year);
      want.error_code = code;
      expected_dates.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (expected_dates.size() == 0) begin
        $error("result arrived with nothing expected: %0d/%0d/%0d code %0d",
               got.cur_month, got.cur_day, got.cur_year, got.error_code);
        errors++;
        return;
      end
      want = expected_dates.pop_front();
      checked++;
      code_seen[want.error_code]++;
      compare_field("cur_month", want.cur_month, got.cur_month);
      compare_field("cur_day", want.cur_day, got.cur_day);
      compare_field("cur_year", want.cur_year, got.cur_year);
      compare_field("is_leap", want.is_leap, got.is_leap);
      compare_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_ready;
  cmd_item_t cmd;
  logic      res_valid;
  logic      res_ready;
  res_item_t res;

  date_tracker tracker;
  bit sender_idle;
  bit receiver_stall;

  calendar_date_up_down_counter_core dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) tracker.check_result(res);
    if (!rst && cmd_valid && cmd_ready) tracker.note_command(cmd);
  end

  // Result side: random stall bursts while enabled.
  initial begin
    res_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (receiver_stall && $urandom_range(0, 2) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      res_ready <= 1'b1;
    end
  end

  // Called and returning at a falling edge.
  task automatic send_cmd(cmd_item_t c);
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (tracker.expected_dates.size() != 0);
  endtask

  function automatic cmd_item_t make_step(int f);
    cmd_item_t c;
    c.func = 2'(f);
    c.load_month = 4'($urandom_range(0, 15));
    c.load_day = 5'($urandom_range(0, 31));
    c.load_year = 14'($urandom_range(0, 16383));
    return c;
  endfunction

  function automatic cmd_item_t make_load(int m, int d, int y);
    cmd_item_t c;
    c.func = FUNC_LOAD;
    c.load_month = 4'(m);
    c.load_day = 5'(d);
    c.load_year = 14'(y);
    return c;
  endfunction

  function automatic int pick_year();
    int specials[15] = '{0, 1, 4, 99, 100, 400, 1600, 1700, 1899, 1900, 2000, 2100,
                         2400, 9996, 9999};
    case ($urandom_range(0, 3))
      0: return specials[$urandom_range(0, 14)];
      1: return $urandom_range(0, 10);
      2: return $urandom_range(9990, 9999);
      default: return $urandom_range(0, 9999);
    endcase
  endfunction

  // A valid load placed so that the following steps cross a month or year boundary.
  function automatic cmd_item_t boundary_load();
    int m;
    int y;
    int last;
    y = pick_year();
    m = $urandom_range(1, 12);
    last = date_tracker::days_of(m, y);
    case ($urandom_range(0, 3))
      0: return make_load(m, last - $urandom_range(0, 2), y);
      1: return make_load(m, 1 + $urandom_range(0, 1), y);
      2: return make_load(MONTH_DEC, DAYS_31 - $urandom_range(0, 3), YEAR_MAX);
      default: return make_load(MONTH_RESET, 1 + $urandom_range(0, 3), 0);
    endcase
  endfunction

  function automatic cmd_item_t any_valid_load();
    int m;
    int y;
    y = pick_year();
    m = $urandom_range(1, 12);
    return make_load(m, $urandom_range(1, date_tracker::days_of(m, y)), y);
  endfunction

  initial begin
    #2_000_000;
    $display("calendar_date_up_down_counter_core: mismatch");
    $finish;
  end

  initial begin
    int sent;
    int choice;
    int run;
    int roll_at;
    bit paused;
    logic [1:0] dir;
    cmd_item_t c;

    tracker = new();
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    sender_idle = 1'b0;
    receiver_stall = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Steps across the reset date in both directions, then the leap rule and each error.
    send_cmd(make_step(FUNC_FWD));
    send_cmd(make_step(FUNC_BACK));
    send_cmd(make_step(FUNC_BACK));
    send_cmd(make_step(FUNC_FWD));
    send_cmd(make_load(MONTH_FEB, DAYS_28, 1900));
    send_cmd(make_step(FUNC_FWD));
    send_cmd(make_load(MONTH_FEB, DAYS_29, 1900));
    send_cmd(make_load(MONTH_FEB, DAYS_29, 2000));
    send_cmd(make_step(FUNC_FWD));
    send_cmd(make_step(FUNC_BACK));
    send_cmd(make_load(4'd3, DAY_RESET, 2004));
    send_cmd(make_step(FUNC_BACK));
    send_cmd(make_load(4'd0, 5'd10, 2000));
    send_cmd(make_load(4'd13, DAY_RESET, 2000));
    send_cmd(make_load(4'd15, 5'd31, 14'd16383));
    send_cmd(make_load(MONTH_RESET, 5'd0, 2000));
    send_cmd(make_load(4'd4, DAYS_31, 2000));
    send_cmd(make_load(MONTH_RESET, DAYS_31, 14'd16383));
    send_cmd(make_load(4'd6, DAYS_30, 14'd10000));
    send_cmd(make_load(MONTH_DEC, DAYS_31, YEAR_MAX));
    send_cmd(make_step(FUNC_FWD));
    send_cmd(make_load(MONTH_RESET, DAY_RESET, 0));
    send_cmd(make_step(FUNC_BACK));
    c = make_load(4'd15, 5'd31, 14'd16383);
    c.func = FUNC_UNUSED;
    send_cmd(c);
    wait_for_drain();

    sent = 0;
    roll_at = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
        sender_idle = 1'b0;
        receiver_stall = 1'b0;
      end else if (sent >= roll_at) begin
        roll_at += 150;
        sender_idle = $urandom_range(0, 1);
        receiver_stall = $urandom_range(0, 1);
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
      choice = $urandom_range(0, 9);
      if (choice < 6) begin
        // Runs of steps in one direction walk across month and year ends.
        dir = (choice < 3) ? FUNC_FWD : FUNC_BACK;
        run = $urandom_range(1, 30);
        repeat (run) begin
          send_cmd(make_step(dir));
          sent++;
        end
      end else if (choice < 8) begin
        send_cmd(boundary_load());
        sent++;
      end else if (choice == 8) begin
        send_cmd(any_valid_load());
        sent++;
      end else begin
        c = make_step($urandom_range(0, 3));
        send_cmd(c);
        if (c.func != FUNC_UNUSED) sent++;
      end
    end

    wait_for_drain();
    repeat (10) @(negedge clk);
    $display("Checked %0d results: %0d ok, %0d bad month, %0d bad day, %0d out of range.",
             tracker.checked, tracker.code_seen[ERR_OK], tracker.code_seen[ERR_BAD_MONTH],
             tracker.code_seen[ERR_BAD_DAY], tracker.code_seen[ERR_RANGE]);
    $display("Stepping crossed %0d year boundaries; dates spanned years %0d to %0d.",
             tracker.year_rollovers, tracker.lowest_year, tracker.highest_year);
    if (tracker.errors == 0 && tracker.expected_dates.size() == 0) begin
      $display("calendar_date_up_down_counter_core: match");
    end else begin
      $display("calendar_date_up_down_counter_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/cdudc_pkg.sv
sv/cdudc_in_stage.sv
sv/cdudc_next.sv
sv/calendar_date_up_down_counter_core.sv
bench/calendar_date_up_down_counter_core_tb.sv
